// ----- hw/rtl/ctq_pkg.sv -----
package ctq_pkg;

   // Default sizing of the table
   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // Fixed field widths of the ports
   localparam int FIELD_KEY_WIDTH = 32;
   localparam int COUNT_WIDTH     = 8;

   localparam logic [COUNT_WIDTH-1:0] TIMEOUT_RESET = 8'd5;

   // Request opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Response kinds
   localparam logic KIND_EXPIRED = 1'b0;
   localparam logic KIND_DROPPED = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic [FIELD_KEY_WIDTH-1:0] key;
   } ctq_req_type;

   typedef struct packed {
      logic                       kind;
      logic [FIELD_KEY_WIDTH-1:0] out_key;
      logic                       last;
   } ctq_rsp_type;

   // Broadcast command to every cell
   typedef struct packed {
      logic enq;    // enqueue or refresh
      logic tick;   // decrement all counters
      logic step;   // emit first expired entry and close the gap
      logic found;  // enqueue key already present somewhere
   } ctq_cmd_type;

   // Signals rippling from cell 0 towards the tail
   typedef struct packed {
      logic valid;  // left neighbour holds an entry
      logic shift;  // an expired entry lies at or before this point
      logic match;  // enqueue key matched at or before this point
      logic more;   // a further expired entry follows the first one
   } ctq_link_type;

   // Cell contents handed to the left neighbour when closing up
   typedef struct packed {
      logic                   valid;
      logic                   expired;
      logic [COUNT_WIDTH-1:0] count;
   } ctq_slot_type;

endpackage

// ----- hw/rtl/ctq_cell.sv -----
module ctq_cell #(
   parameter int KEY_WIDTH = ctq_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ctq_pkg::ctq_cmd_type              cmd,
   input  logic [KEY_WIDTH-1:0]              cmd_key,
   input  logic [ctq_pkg::COUNT_WIDTH-1:0]   timeout,
   input  ctq_pkg::ctq_link_type             link_in,
   output ctq_pkg::ctq_link_type             link_out,
   input  logic [KEY_WIDTH-1:0]              emit_key_in,
   output logic [KEY_WIDTH-1:0]              emit_key_out,
   input  ctq_pkg::ctq_slot_type             right_slot,
   input  logic [KEY_WIDTH-1:0]              right_key,
   output ctq_pkg::ctq_slot_type             own_slot,
   output logic [KEY_WIDTH-1:0]              own_key
);
   import ctq_pkg::*;

   logic                   valid_ff, valid_in;
   logic                   expired_ff, expired_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;

   logic hit;
   logic exp_here;

   assign hit      = valid_ff && (key_ff == cmd_key);
   assign exp_here = valid_ff && expired_ff;

   // Ripple links to the next cell
   always_comb begin
      link_out.valid = valid_ff;
      link_out.shift = link_in.shift | exp_here;
      link_out.match = link_in.match | hit;
      link_out.more  = link_in.more | (link_in.shift & exp_here);
   end

   // The first expired key is carried on unchanged past later cells
   assign emit_key_out = link_in.shift ? emit_key_in : key_ff;

   assign own_slot = '{valid: valid_ff, expired: expired_ff, count: count_ff};
   assign own_key  = key_ff;

   // Next state of the cell
   always_comb begin
      valid_in   = valid_ff;
      expired_in = expired_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      if (cmd.enq) begin
         if (hit) begin
            count_in = timeout;
         end else if (!cmd.found && !valid_ff && link_in.valid) begin
            // first free cell takes the new key
            valid_in = 1'b1;
            key_in   = cmd_key;
            count_in = timeout;
         end
      end else if (cmd.tick) begin
         count_in   = count_ff - 1'b1;
         expired_in = (count_ff == COUNT_WIDTH'(1));
      end else if (cmd.step && link_out.shift) begin
         // close up behind the emitted entry
         valid_in   = right_slot.valid;
         expired_in = right_slot.expired;
         count_in   = right_slot.count;
         key_in     = right_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      expired_ff <= expired_in;
      count_ff   <= count_in;
      key_ff     <= key_in;
   end

endmodule

// ----- hw/rtl/coalescing_timeout_queue_top.sv -----
// Enqueue: one request per cycle while the response register is free; a drop
//   response for a full table appears in the cycle after the request.
// Tick: decrements every counter, then emits the expired keys in turn, each
//   when the response register is free (stalled under response back-pressure).
// Reset clears the entry valid flags, the sequencer and the response valid flag,
//   and sets the timeout to 5. Key, count and expired stores are not cleared.
module coalescing_timeout_queue_top #(
   parameter int DEPTH     = ctq_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = ctq_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ctq_pkg::ctq_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ctq_pkg::ctq_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ctq_pkg::COUNT_WIDTH-1:0]      csr_data
);
   import ctq_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                   state_ff, state_in;
   logic [COUNT_WIDTH-1:0] timeout_ff, timeout_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ctq_rsp_type            rsp_ff, rsp_in;

   ctq_cmd_type            cmd;
   ctq_link_type           link   [DEPTH+1];
   logic [KEY_WIDTH-1:0]   emit   [DEPTH+1];
   ctq_slot_type           slot   [DEPTH+1];
   logic [KEY_WIDTH-1:0]   key_q  [DEPTH+1];

   logic                       out_free;
   logic                       accept;
   logic [KEY_WIDTH-1:0]       req_key_w;
   logic [KEY_WIDTH+FIELD_KEY_WIDTH-1:0] req_key_ext;
   logic [KEY_WIDTH+FIELD_KEY_WIDTH-1:0] emit_key_ext;
   logic [KEY_WIDTH+FIELD_KEY_WIDTH-1:0] drop_key_ext;

   // Key width conversion between ports and table
   assign req_key_ext  = {{KEY_WIDTH{1'b0}}, req_data.key};
   assign req_key_w    = req_key_ext[KEY_WIDTH-1:0];
   assign emit_key_ext = {{FIELD_KEY_WIDTH{1'b0}}, emit[DEPTH]};
   assign drop_key_ext = {{FIELD_KEY_WIDTH{1'b0}}, req_key_w};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Chain ends
   assign link[0] = '{valid: 1'b1, shift: 1'b0, match: 1'b0, more: 1'b0};
   assign emit[0] = '0;
   assign slot[DEPTH]  = '{valid: 1'b0, expired: 1'b0, count: '0};
   assign key_q[DEPTH] = '0;

   // Row of table cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ctq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .cmd_key      (req_key_w),
         .timeout      (timeout_ff),
         .link_in      (link[g]),
         .link_out     (link[g+1]),
         .emit_key_in  (emit[g]),
         .emit_key_out (emit[g+1]),
         .right_slot   (slot[g+1]),
         .right_key    (key_q[g+1]),
         .own_slot     (slot[g]),
         .own_key      (key_q[g])
      );
   end

   // Sequencer and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd          = '{enq: 1'b0, tick: 1'b0, step: 1'b0, found: link[DEPTH].match};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_TICK) begin
                  cmd.tick = 1'b1;
                  state_in = ST_DRAIN;
               end else begin
                  cmd.enq = 1'b1;
                  // table full and key absent: report the drop
                  if (!link[DEPTH].match && link[DEPTH].valid) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{kind: KIND_DROPPED,
                                out_key: drop_key_ext[FIELD_KEY_WIDTH-1:0],
                                last: 1'b1};
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!link[DEPTH].shift) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: KIND_EXPIRED,
                          out_key: emit_key_ext[FIELD_KEY_WIDTH-1:0],
                          last: !link[DEPTH].more};
               if (!link[DEPTH].more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Timeout register
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- tb/sv/ctq_expiry_checker.sv -----
module ctq_expiry_checker #(
   parameter int DEPTH = ctq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  ctq_pkg::ctq_req_type                 req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  ctq_pkg::ctq_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ctq_pkg::COUNT_WIDTH-1:0]      csr_data,
   output int unsigned                          outstanding,
   output int unsigned                          failures,
   output int unsigned                          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ctq_pkg::*;

   // Shadow copy of the table, in arrival order
   logic [FIELD_KEY_WIDTH-1:0] table_keys [DEPTH];
   logic [COUNT_WIDTH-1:0]     table_counts [DEPTH];
   int unsigned                fill = 0;
   logic [COUNT_WIDTH-1:0]     timeout_ticks = TIMEOUT_RESET;

   // Responses still owed by the block, oldest first
   ctq_rsp_type due_results [$];
   int unsigned mismatches = 0;
   int unsigned checked = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns: response %0d, %s: got %0h, expected %0h",
               $time, checked, what, got, want);
      mismatches++;
   endtask

   // Update the shadow table for one request and queue the responses it owes
   function automatic void apply_request(input ctq_req_type r);
      ctq_rsp_type            expired [DEPTH];
      ctq_rsp_type            dropped;
      logic [COUNT_WIDTH-1:0] left;
      int unsigned            kept;
      int unsigned            n;
      int unsigned            i;
      bit                     hit;
      hit  = 1'b0;
      kept = 0;
      n    = 0;
      if (r.opcode == OP_ENQUEUE) begin
         // keys are unique, only the first match is reloaded
         for (i = 0; i < fill; i++) begin
            if (!hit && table_keys[i] == r.key) begin
               table_counts[i] = timeout_ticks;
               hit = 1'b1;
            end
         end
         if (!hit && fill < DEPTH) begin
            table_keys[fill]   = r.key;
            table_counts[fill] = timeout_ticks;
            fill++;
         end else if (!hit) begin
            dropped.kind    = KIND_DROPPED;
            dropped.out_key = r.key;
            dropped.last    = 1'b1;
            due_results.push_back(dropped);
         end
      end else begin
         // decrement all, emit the ones reaching zero, close up the rest
         for (i = 0; i < fill; i++) begin
            left = table_counts[i] - 1'b1;
            if (left == '0) begin
               expired[n].kind    = KIND_EXPIRED;
               expired[n].out_key = table_keys[i];
               expired[n].last    = 1'b0;
               n++;
            end else begin
               table_keys[kept]   = table_keys[i];
               table_counts[kept] = left;
               kept++;
            end
         end
         fill = kept;
         if (n > 0) expired[n-1].last = 1'b1;
         for (i = 0; i < n; i++) due_results.push_back(expired[i]);
      end
   endfunction

   task automatic check_response(input ctq_rsp_type got);
      ctq_rsp_type want;
      checked++;
      if (due_results.size() == 0) begin
         report("response with none owed, key", got.out_key, '0);
      end else begin
         want = due_results.pop_front();
         if (got.kind != want.kind) report("kind", 32'(got.kind), 32'(want.kind));
         if (got.out_key != want.out_key) report("out_key", got.out_key, want.out_key);
         if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
      end
   endtask

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         fill          = 0;
         timeout_ticks = TIMEOUT_RESET;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) timeout_ticks = csr_data;
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         if (req_valid && req_ready) apply_request(req_data);
      end
      outstanding     <= due_results.size();
      failures        <= mismatches;
      results_checked <= checked;
   end

endmodule

// ----- tb/sv/coalescing_timeout_queue_top_tb.sv -----
module coalescing_timeout_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctq_pkg::*;

   localparam int POOL_SIZE = 24;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   ctq_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   ctq_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_WIDTH-1:0] csr_data = '0;

   int unsigned outstanding;
   int unsigned failures;
   int unsigned results_checked;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   bit          steady = 1'b0;

   always #2 clock = ~clock;

   coalescing_timeout_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   ctq_expiry_checker expiry_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .outstanding     (outstanding),
      .failures        (failures),
      .results_checked (results_checked)
   );

   // Receiver back-pressure, switched off during the steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99, 0) >= 24);
   end

   // One request; valid stays up from the previous request unless we idle
   task automatic send_request(input logic op, input logic [FIELD_KEY_WIDTH-1:0] k);
      @(negedge clock);
      while (!steady && $urandom_range(99, 0) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, key: k};
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Stop sending and wait for every owed response, then let a quiet tick finish
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [COUNT_WIDTH-1:0] ticks);
      wait_until_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [FIELD_KEY_WIDTH-1:0] pool [POOL_SIZE];
      logic [FIELD_KEY_WIDTH-1:0] wrap_key [2];
      int unsigned                i;
      int unsigned                p;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: quiet tick on empty table, extreme keys, refresh, paired expiry
      send_request(OP_TICK, 32'h0000_0000);
      send_request(OP_ENQUEUE, 32'h0000_0000);
      send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
      send_request(OP_ENQUEUE, 32'hA5A5_A5A5);
      send_request(OP_ENQUEUE, 32'h0000_0000);
      repeat (2) send_request(OP_TICK, $urandom());
      send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
      repeat (6) send_request(OP_TICK, $urandom());

      // Long timeout: fill the table, overflow it, then all keys expire on one tick
      write_timeout(8'd40);
      for (i = 0; i < 18; i++) send_request(OP_ENQUEUE, 32'h5A00_0000 | i);
      send_request(OP_ENQUEUE, 32'h5A00_0003);
      repeat (40) send_request(OP_TICK, $urandom());

      // Zero timeout wraps, so keys survive; a refresh at timeout 1 then expires them
      write_timeout(8'd0);
      foreach (wrap_key[j]) begin
         wrap_key[j] = $urandom();
         send_request(OP_ENQUEUE, wrap_key[j]);
      end
      repeat (20) send_request(OP_TICK, $urandom());
      write_timeout(8'd1);
      foreach (wrap_key[j]) send_request(OP_ENQUEUE, wrap_key[j]);
      send_request(OP_TICK, $urandom());

      // Random phases: mostly a small key pool so keys get refreshed and the table fills
      for (p = 0; p < 5; p++) begin
         write_timeout(p == 0 ? 8'd1 : 8'($urandom_range(6, 2)));
         steady = (p == 2);
         foreach (pool[j]) pool[j] = $urandom();
         for (i = 0; i < 50; i++) begin
            if (p == 3 && i == 25) wait_until_drained();
            if ($urandom_range(99, 0) < 20)
               send_request(OP_TICK, $urandom());
            else if ($urandom_range(99, 0) < 85)
               send_request(OP_ENQUEUE, pool[$urandom_range(POOL_SIZE - 1, 0)]);
            else
               send_request(OP_ENQUEUE, $urandom());
         end
      end
      steady = 1'b0;

      wait_until_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests across %0d timeout settings, checked %0d responses.",
               requests_sent, settings_used, results_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
